// ===== rtl/arxrls_pkg.sv =====
// Shared types, constants and saturating helpers for the ARX RLS estimator.
`timescale 1ns / 1ps
package arxrls_pkg;

  localparam int MODEL_ORDER = 4;
  localparam int NRATE = MODEL_ORDER - MODEL_ORDER / 2;
  localparam int NCMD = MODEL_ORDER / 2;
  localparam int IW = $clog2(MODEL_ORDER);
  localparam logic [IW-1:0] LAST = IW'(MODEL_ORDER - 1);

  // configuration register indexes
  localparam logic [2:0] REG_LAMBDA  = 3'd0;
  localparam logic [2:0] REG_COEF_R1 = 3'd1;
  localparam logic [2:0] REG_COV     = 3'd5;

  localparam logic [30:0] LAMBDA_RST = 31'd1073634450;
  localparam logic [30:0] LAM_MIN = 31'd536870912;
  localparam logic [30:0] LAM_MAX = 31'd1073741824;
  localparam logic [46:0] COV_DIAG_RST = 47'd17592186044;
  localparam logic signed [31:0] COEF_RST [4] = '{32'sd29091693, -32'sd13136560,
                                                  32'sd801112, 32'sd0};

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef logic [3:0] op_t;
  localparam op_t OP_NONE  = 4'd0;
  localparam op_t OP_START = 4'd1;
  localparam op_t OP_PV    = 4'd2;
  localparam op_t OP_PW    = 4'd3;
  localparam op_t OP_SQ    = 4'd4;
  localparam op_t OP_YH    = 4'd5;
  localparam op_t OP_D     = 4'd6;
  localparam op_t OP_K     = 4'd7;
  localparam op_t OP_KZ    = 4'd8;
  localparam op_t OP_KE    = 4'd9;
  localparam op_t OP_KW    = 4'd10;
  localparam op_t OP_PD    = 4'd11;
  localparam op_t OP_FIN   = 4'd12;

  typedef struct packed {
    logic          go;
    op_t           op;
    logic [IW-1:0] i;
    logic [IW-1:0] j;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic d_pos;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic               ovf;
    logic signed [63:0] val;
  } sat_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } c32_t;

  typedef struct packed {
    logic               ovf;
    logic signed [47:0] val;
  } c48_t;

  function automatic sat_t sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    sat_t r;
    s = {a[63], a} + {b[63], b};
    r.ovf = s[64] ^ s[63];
    r.val = r.ovf ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic sat_t sat_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    sat_t r;
    s = {a[63], a} - {b[63], b};
    r.ovf = s[64] ^ s[63];
    r.val = r.ovf ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic c32_t clamp32(logic signed [63:0] x);
    c32_t r;
    r.ovf = !((&x[63:31]) || !(|x[63:31]));
    r.val = r.ovf ? (x[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : x[31:0];
    return r;
  endfunction

  function automatic c48_t clamp48(logic signed [63:0] x);
    c48_t r;
    r.ovf = !((&x[63:47]) || !(|x[63:47]));
    r.val = r.ovf ? (x[63] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF) : x[47:0];
    return r;
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // coefficient slot of rate1, rate2, cmd1, cmd2; -1 when the tap is absent
  function automatic int coef_slot(int which);
    case (which)
      0: return 0;
      1: return (NRATE >= 2) ? 1 : -1;
      2: return NRATE;
      default: return (NCMD >= 2) ? NRATE + 1 : -1;
    endcase
  endfunction

  // reset value of coefficient slot k; zero where no init register maps to it
  function automatic logic signed [31:0] coef_rst_at(int k);
    for (int n = 0; n < 4; n++)
      if (coef_slot(n) == k) return COEF_RST[n];
    return 32'sd0;
  endfunction

endpackage

// ===== rtl/arxrls_mul.sv =====
// Multi-cycle 64x64 signed multiply with round-half-up shift and saturation.
`timescale 1ns / 1ps
module arxrls_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic               sh44,
  output logic               done,
  output logic signed [63:0] res,
  output logic               ovf
);
  import arxrls_pkg::*;

  logic         busy;
  logic [2:0]   step;
  logic [63:0]  ua, ub;
  logic         neg, s44;
  logic [127:0] acc;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] part, rbit, rnd;
  logic signed [127:0] shv;
  logic         fits;

  always_comb begin
    pa = step[1] ? ua[63:32] : ua[31:0];
    pb = step[0] ? ub[63:32] : ub[31:0];
    pp = pa * pb;
    case (step[1:0])
      2'd0:    part = {64'd0, pp};
      2'd3:    part = {pp, 64'd0};
      default: part = {32'd0, pp, 32'd0};
    endcase
    rbit = s44 ? (128'd1 << 43) : (128'd1 << 23);
    rnd  = acc + rbit;
    shv  = $signed(rnd) >>> (s44 ? 44 : 24);
    fits = (&shv[127:63]) || !(|shv[127:63]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
        ua   <= mag64(a);
        ub   <= mag64(b);
        neg  <= a[63] ^ b[63];
        s44  <= sh44;
        acc  <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step < 3'd4) begin
          acc <= acc + part;
        end else if (step == 3'd4) begin
          if (neg) acc <= -acc;
        end else begin
          res  <= fits ? shv[63:0] : (shv[127] ? S64_MIN : S64_MAX);
          ovf  <= !fits;
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

// ===== rtl/arxrls_div.sv =====
// Restoring divider, one quotient bit per cycle: trunc(n * 2^s / d), saturated.
`timescale 1ns / 1ps
module arxrls_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] n,
  input  logic               sh44,
  input  logic [63:0]        d,
  output logic               done,
  output logic signed [63:0] res,
  output logic               ovf
);
  import arxrls_pkg::*;

  logic         busy, fin, neg;
  logic [6:0]   cnt;
  logic [127:0] dvd, q;
  logic [63:0]  rem, dv;
  logic [63:0]  t;
  logic         ge, over;

  always_comb begin
    t    = {rem[62:0], dvd[127]};
    ge   = t >= dv;
    over = |q[127:63];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= 7'd127;
        dvd  <= {64'd0, mag64(n)} << (sh44 ? 44 : 30);
        rem  <= '0;
        q    <= '0;
        dv   <= d;
        neg  <= n[63];
      end else if (fin) begin
        fin  <= 1'b0;
        busy <= 1'b0;
        done <= 1'b1;
        ovf  <= over;
        if (over) res <= neg ? S64_MIN : S64_MAX;
        else      res <= neg ? -$signed(q[63:0]) : $signed(q[63:0]);
      end else if (busy) begin
        rem <= ge ? t - dv : t;
        q   <= {q[126:0], ge};
        dvd <= {dvd[126:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd0) fin <= 1'b1;
      end
    end
  end
endmodule

// ===== rtl/arxrls_dp.sv =====
// Datapath: estimator state, working vectors, arithmetic units and output register.
`timescale 1ns / 1ps
module arxrls_dp (
  input  logic                clk,
  input  logic                rst,
  input  arxrls_pkg::cmd_t    cmd,
  output arxrls_pkg::stat_t   stat,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [46:0]         wr_data,
  input  logic signed [31:0]  measured_rate,
  input  logic signed [31:0]  command_rate,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [31:0]  coef_rate1,
  output logic signed [31:0]  coef_rate2,
  output logic signed [31:0]  coef_cmd1,
  output logic signed [31:0]  coef_cmd2,
  output logic signed [31:0]  prediction_error,
  output logic                clipped
);
  import arxrls_pkg::*;

  localparam int N = MODEL_ORDER;

  // architectural state
  logic [30:0]        lam;
  logic signed [31:0] phi  [N];
  logic signed [31:0] coef [N];
  logic signed [47:0] cov  [N][N];

  // per-request working values
  logic signed [63:0] v [N];
  logic signed [63:0] w [N];
  logic signed [63:0] kv [N];
  logic signed [63:0] sq, yhat, dreg, tmp;
  logic signed [31:0] y, u, e;
  logic               clip;
  logic signed [31:0] oc [4];

  logic [30:0]        lam_c;
  logic signed [47:0] cov_rd;
  logic signed [63:0] cov_x, ma, mb, acc_sel, dn, mres, dres;
  logic [63:0]        dd;
  logic               mstart, dstart, msh44, mdone, ddone, movf, dovf;
  sat_t               wb_add, wb_sub, d_sum, e_sub;
  c32_t               e_c, coef_c;
  c48_t               cov_c;

  always_comb begin
    if (lam < LAM_MIN)      lam_c = LAM_MIN;
    else if (lam > LAM_MAX) lam_c = LAM_MAX;
    else                    lam_c = lam;

    cov_rd = (cmd.op == OP_PW) ? cov[cmd.j][cmd.i] : cov[cmd.i][cmd.j];
    cov_x  = {{16{cov_rd[47]}}, cov_rd};

    case (cmd.op)
      OP_PV, OP_PW: begin ma = cov_x; mb = {{32{phi[cmd.j][31]}}, phi[cmd.j]}; end
      OP_SQ:   begin ma = {{32{phi[cmd.i][31]}}, phi[cmd.i]}; mb = v[cmd.i]; end
      OP_YH:   begin
        ma = {{32{coef[cmd.i][31]}}, coef[cmd.i]};
        mb = {{32{phi[cmd.i][31]}}, phi[cmd.i]};
      end
      OP_KE:   begin ma = kv[cmd.i]; mb = {{32{e[31]}}, e}; end
      OP_KW:   begin ma = kv[cmd.i]; mb = w[cmd.j]; end
      default: begin ma = '0; mb = '0; end
    endcase
    msh44  = (cmd.op == OP_KE) || (cmd.op == OP_KW);
    mstart = cmd.go && ((cmd.op == OP_PV) || (cmd.op == OP_PW) || (cmd.op == OP_SQ) ||
                        (cmd.op == OP_YH) || msh44);

    dstart = cmd.go && ((cmd.op == OP_K) || (cmd.op == OP_PD));
    dn     = (cmd.op == OP_K) ? v[cmd.i] : tmp;
    dd     = (cmd.op == OP_K) ? 64'(dreg) : {33'd0, lam_c};

    case (cmd.op)
      OP_PV:   acc_sel = v[cmd.i];
      OP_PW:   acc_sel = w[cmd.i];
      OP_SQ:   acc_sel = sq;
      OP_YH:   acc_sel = yhat;
      default: acc_sel = {{32{coef[cmd.i][31]}}, coef[cmd.i]};
    endcase
    wb_add = sat_add(acc_sel, mres);
    wb_sub = sat_sub(cov_x, mres);
    coef_c = clamp32(wb_add.val);
    cov_c  = clamp48(dres);

    d_sum = sat_add({19'd0, lam_c, 14'd0}, sq);
    e_sub = sat_sub({{32{y[31]}}, y}, yhat);
    e_c   = clamp32(e_sub.val);

    stat.mul_done = mdone;
    stat.div_done = ddone;
    stat.d_pos    = !dreg[63] && (dreg != 64'sd0);
    stat.out_busy = out_valid && !out_ready;
  end

  arxrls_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .sh44(msh44),
    .done(mdone), .res(mres), .ovf(movf)
  );

  arxrls_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .n(dn), .sh44(cmd.op == OP_K), .d(dd),
    .done(ddone), .res(dres), .ovf(dovf)
  );

  // state with reset values; config writes land here too
  always_ff @(posedge clk) begin
    if (rst) begin
      lam <= LAMBDA_RST;
      for (int a = 0; a < N; a++) begin
        phi[a]  <= '0;
        coef[a] <= coef_rst_at(a);
        for (int b = 0; b < N; b++)
          cov[a][b] <= (a == b) ? {1'b0, COV_DIAG_RST} : '0;
      end
    end else begin
      if (wr_en) begin
        if (wr_index == REG_LAMBDA) lam <= wr_data[30:0];
        for (int n = 0; n < 4; n++)
          if (wr_index == REG_COEF_R1 + 3'(n) && coef_slot(n) >= 0)
            coef[IW'(coef_slot(n))] <= wr_data[31:0];
        if (wr_index == REG_COV)
          for (int a = 0; a < N; a++)
            for (int b = 0; b < N; b++)
              cov[a][b] <= (a == b) ? {1'b0, wr_data} : '0;
      end
      if (mdone && cmd.op == OP_KE) coef[cmd.i] <= coef_c.val;
      if (ddone && cmd.op == OP_PD) cov[cmd.i][cmd.j] <= cov_c.val;
      if (cmd.go && cmd.op == OP_FIN) begin
        phi[0] <= y;
        for (int n = 1; n < NRATE; n++) phi[n] <= phi[n-1];
        phi[NRATE] <= u;
        for (int n = NRATE + 1; n < N; n++) phi[n] <= phi[n-1];
      end
    end
  end

  // working values of one request
  always_ff @(posedge clk) begin
    if (cmd.go && cmd.op == OP_START) begin
      y    <= measured_rate;
      u    <= command_rate;
      sq   <= '0;
      yhat <= '0;
      clip <= 1'b0;
      for (int a = 0; a < N; a++) begin
        v[a] <= '0;
        w[a] <= '0;
      end
    end
    if (mdone) begin
      case (cmd.op)
        OP_PV:   v[cmd.i] <= wb_add.val;
        OP_PW:   w[cmd.i] <= wb_add.val;
        OP_SQ:   sq <= wb_add.val;
        OP_YH:   yhat <= wb_add.val;
        OP_KW:   tmp <= wb_sub.val;
        default: ;
      endcase
      if (movf || (cmd.op == OP_KW ? wb_sub.ovf : wb_add.ovf) ||
          (cmd.op == OP_KE && coef_c.ovf))
        clip <= 1'b1;
    end
    if (ddone) begin
      if (cmd.op == OP_K) kv[cmd.i] <= dres;
      if (dovf || (cmd.op == OP_PD && cov_c.ovf)) clip <= 1'b1;
    end
    if (cmd.go && cmd.op == OP_KZ) kv[cmd.i] <= '0;
    if (cmd.go && cmd.op == OP_D) begin
      dreg <= d_sum.val;
      e    <= e_c.val;
      if (d_sum.ovf || e_sub.ovf || e_c.ovf) clip <= 1'b1;
    end
    if (cmd.go && cmd.op == OP_FIN) begin
      for (int n = 0; n < 4; n++)
        oc[n] <= (coef_slot(n) >= 0) ? coef[IW'(coef_slot(n))] : 32'sd0;
      prediction_error <= e;
      clipped          <= clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.go && cmd.op == OP_FIN) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign coef_rate1 = oc[0];
  assign coef_rate2 = oc[1];
  assign coef_cmd1  = oc[2];
  assign coef_cmd2  = oc[3];
endmodule

// ===== rtl/arxrls_ctrl.sv =====
// Sequencer: steps the datapath through the prediction, gain, error, coefficient and covariance update.
`timescale 1ns / 1ps
module arxrls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  arxrls_pkg::stat_t stat,
  output arxrls_pkg::cmd_t  cmd
);
  import arxrls_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PV   = 4'd1;
  localparam logic [3:0] ST_PW   = 4'd2;
  localparam logic [3:0] ST_SQ   = 4'd3;
  localparam logic [3:0] ST_YH   = 4'd4;
  localparam logic [3:0] ST_D    = 4'd5;
  localparam logic [3:0] ST_K    = 4'd6;
  localparam logic [3:0] ST_KE   = 4'd7;
  localparam logic [3:0] ST_KW   = 4'd8;
  localparam logic [3:0] ST_PD   = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  logic [3:0]    state, state_next;
  logic          pend, pend_next;
  logic [IW-1:0] i, i_next, j, j_next;
  logic          i_last, j_last;

  always_comb begin
    state_next = state;
    pend_next  = pend;
    i_next     = i;
    j_next     = j;
    i_last     = (i == LAST);
    j_last     = (j == LAST);
    cmd.go     = 1'b0;
    cmd.op     = OP_NONE;
    cmd.i      = i;
    cmd.j      = j;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.op = OP_START;
        if (in_valid) begin
          cmd.go     = 1'b1;
          i_next     = '0;
          j_next     = '0;
          state_next = ST_PV;
        end
      end
      ST_PV, ST_PW, ST_SQ, ST_YH, ST_KE, ST_KW, ST_PD,
      ST_K: begin
        case (state)
          ST_PV:   cmd.op = OP_PV;
          ST_PW:   cmd.op = OP_PW;
          ST_SQ:   cmd.op = OP_SQ;
          ST_YH:   cmd.op = OP_YH;
          ST_KE:   cmd.op = OP_KE;
          ST_KW:   cmd.op = OP_KW;
          ST_PD:   cmd.op = OP_PD;
          default: cmd.op = stat.d_pos ? OP_K : OP_KZ;
        endcase
        if (state == ST_K && !stat.d_pos) begin
          // no gain: zero it directly, without the divider
          cmd.go = 1'b1;
          i_next = i_last ? '0 : i + 1'b1;
          if (i_last) state_next = ST_KE;
        end else if (!pend) begin
          cmd.go    = 1'b1;
          pend_next = 1'b1;
        end else if ((state == ST_K || state == ST_PD) ? stat.div_done : stat.mul_done) begin
          pend_next = 1'b0;
          case (state)
            ST_PV: state_next = ST_PW;
            ST_KW: state_next = ST_PD;
            ST_PW, ST_PD: begin
              j_next = j_last ? '0 : j + 1'b1;
              if (j_last) i_next = i_last ? '0 : i + 1'b1;
              if (j_last && i_last) state_next = (state == ST_PW) ? ST_SQ : ST_FIN;
              else                  state_next = (state == ST_PW) ? ST_PV : ST_KW;
            end
            default: begin
              i_next = i_last ? '0 : i + 1'b1;
              if (i_last) begin
                case (state)
                  ST_SQ:   state_next = ST_YH;
                  ST_YH:   state_next = ST_D;
                  ST_K:    state_next = ST_KE;
                  default: state_next = ST_KW;
                endcase
              end
            end
          endcase
        end
      end
      ST_D: begin
        cmd.op     = OP_D;
        cmd.go     = 1'b1;
        i_next     = '0;
        state_next = ST_K;
      end
      ST_FIN: begin
        cmd.op = OP_FIN;
        if (!stat.out_busy) begin
          cmd.go     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      i     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      i     <= i_next;
      j     <= j_next;
    end
  end
endmodule

// ===== rtl/arx_recursive_least_squares.sv =====
// Top level of the fourth-order ARX recursive least squares estimator.
//
// Input channel (in_valid/in_ready) takes one request per sample period:
// measured_rate and command_rate, Q8.24. The output channel (out_valid/
// out_ready) returns the four updated coefficients (Q8.24), the prediction
// error and a clipped flag telling whether anything saturated in that step.
// Most of the time from acceptance to result is spent in the shared
// one-bit-per-cycle divider: up to 20 divisions (four gains, sixteen
// covariance entries); the 60 multiplies go through the shared 32x32
// partial-product multiplier.
// One request is worked on at a time; in_ready is high whenever the
// sequencer is idle, also while a finished result still waits in the
// output register. If the receiver stalls, the next result waits at the end
// of its computation until the output register frees.
// Reset (rst, synchronous) clears the regressor, loads coefficients and
// covariance from the register reset values and empties the output.
// Writes on wr_en/wr_index/wr_data take effect at once; index 0 is lambda,
// 1-4 the initial coefficients (each reloads its coefficient) and 5 the
// covariance diagonal (reloads the whole covariance). Write only when idle.
`timescale 1ns / 1ps
module arx_recursive_least_squares (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [46:0]        wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] measured_rate,
  input  logic signed [31:0] command_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] coef_rate1,
  output logic signed [31:0] coef_rate2,
  output logic signed [31:0] coef_cmd1,
  output logic signed [31:0] coef_cmd2,
  output logic signed [31:0] prediction_error,
  output logic               clipped
);
  import arxrls_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  arxrls_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  arxrls_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .measured_rate(measured_rate), .command_rate(command_rate),
    .out_ready(out_ready), .out_valid(out_valid),
    .coef_rate1(coef_rate1), .coef_rate2(coef_rate2),
    .coef_cmd1(coef_cmd1), .coef_cmd2(coef_cmd2),
    .prediction_error(prediction_error), .clipped(clipped)
  );
endmodule

// ===== sim/rls_result_monitor.sv =====
// Monitor for the ARX RLS estimator: predicts each result and compares it.
`timescale 1ns / 1ps
module rls_result_monitor (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [46:0]        wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] measured_rate,
  input  logic signed [31:0] command_rate,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] coef_rate1,
  input  logic signed [31:0] coef_rate2,
  input  logic signed [31:0] coef_cmd1,
  input  logic signed [31:0] coef_cmd2,
  input  logic signed [31:0] prediction_error,
  input  logic               clipped,
  output int                 err_count,
  output int                 outstanding,
  output int                 checked_count,
  output int                 clip_count
);
  import arxrls_pkg::*;

  typedef struct {
    logic signed [31:0] c_r1;
    logic signed [31:0] c_r2;
    logic signed [31:0] c_u1;
    logic signed [31:0] c_u2;
    logic signed [31:0] err;
    logic               clip;
  } rls_result_t;

  localparam longint COV_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint COV_LO = -COV_HI - 1;
  localparam longint I32_HI = 64'sd2147483647;
  localparam longint I32_LO = -64'sd2147483648;

  rls_result_t pending_results[$];

  logic [30:0]        lambda_q30;
  logic signed [31:0] coef_init [4];
  longint             cov_diag;
  longint             phi [MODEL_ORDER];
  longint             theta [MODEL_ORDER];
  longint             cov [MODEL_ORDER][MODEL_ORDER];
  logic               sat_seen;

  function automatic longint sadd(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_seen = 1'b1;
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic longint ssub(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      sat_seen = 1'b1;
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic longint clampv(longint x, longint lo, longint hi);
    if (x < lo) begin
      sat_seen = 1'b1;
      return lo;
    end
    if (x > hi) begin
      sat_seen = 1'b1;
      return hi;
    end
    return x;
  endfunction

  // round half up at the shift, then saturate to 64 bits
  function automatic longint mul_round(longint a, longint b, int s);
    logic signed [127:0] p;
    logic signed [127:0] q;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    p = p + (128'sd1 <<< (s - 1));
    q = p >>> s;
    if ((&q[127:63]) || !(|q[127:63])) return q[63:0];
    sat_seen = 1'b1;
    return q[127] ? S64_MIN : S64_MAX;
  endfunction

  // trunc(n * 2^s / d), d > 0
  function automatic longint div_trunc(longint n, int s, longint d);
    logic [63:0]  un;
    logic [127:0] num;
    logic [127:0] quo;
    un = n[63] ? (~n + 64'd1) : n;
    num = {64'd0, un} << s;
    quo = num / {64'd0, d};
    if (|quo[127:63]) begin
      sat_seen = 1'b1;
      return n[63] ? S64_MIN : S64_MAX;
    end
    return n[63] ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic void load_cov();
    for (int i = 0; i < MODEL_ORDER; i++)
      for (int j = 0; j < MODEL_ORDER; j++)
        cov[i][j] = (i == j) ? cov_diag : 0;
  endfunction

  function automatic void load_coef(int which);
    int k;
    case (which)
      0: k = 0;
      1: k = (NRATE >= 2) ? 1 : -1;
      2: k = NRATE;
      default: k = (NCMD >= 2) ? NRATE + 1 : -1;
    endcase
    if (k >= 0 && k < MODEL_ORDER) theta[k] = coef_init[which];
  endfunction

  function automatic longint tap(int which);
    case (which)
      0: return theta[0];
      1: return (NRATE >= 2) ? theta[1] : 0;
      2: return theta[NRATE];
      default: return (NCMD >= 2) ? theta[NRATE + 1] : 0;
    endcase
  endfunction

  function automatic void model_reset();
    lambda_q30 = LAMBDA_RST;
    for (int k = 0; k < 4; k++) coef_init[k] = COEF_RST[k];
    cov_diag = COV_DIAG_RST;
    for (int i = 0; i < MODEL_ORDER; i++) begin
      phi[i] = 0;
      theta[i] = 0;
    end
    for (int k = 0; k < 4; k++) load_coef(k);
    load_cov();
  endfunction

  function automatic void apply_write(logic [2:0] idx, logic [46:0] data);
    if (idx == REG_LAMBDA) begin
      lambda_q30 = data[30:0];
    end else if (idx >= REG_COEF_R1 && idx < REG_COV) begin
      coef_init[idx - REG_COEF_R1] = data[31:0];
      load_coef(idx - REG_COEF_R1);
    end else if (idx == REG_COV) begin
      cov_diag = {17'd0, data};
      load_cov();
    end
  endfunction

  function automatic rls_result_t rls_update(longint y, longint u);
    longint lam, sq, yhat, d, e;
    longint v [MODEL_ORDER];
    longint w [MODEL_ORDER];
    longint gain [MODEL_ORDER];
    rls_result_t r;
    sat_seen = 1'b0;
    lam = lambda_q30;
    if (lam < LAM_MIN) lam = LAM_MIN;
    if (lam > LAM_MAX) lam = LAM_MAX;
    sq = 0;
    yhat = 0;
    for (int i = 0; i < MODEL_ORDER; i++) begin
      v[i] = 0;
      w[i] = 0;
      for (int j = 0; j < MODEL_ORDER; j++) begin
        v[i] = sadd(v[i], mul_round(cov[i][j], phi[j], 24));
        w[i] = sadd(w[i], mul_round(phi[j], cov[j][i], 24));
      end
    end
    for (int i = 0; i < MODEL_ORDER; i++) begin
      sq = sadd(sq, mul_round(phi[i], v[i], 24));
      yhat = sadd(yhat, mul_round(theta[i], phi[i], 24));
    end
    d = sadd(lam * 16384, sq);
    for (int i = 0; i < MODEL_ORDER; i++)
      gain[i] = (d > 0) ? div_trunc(v[i], 44, d) : 0;
    e = clampv(ssub(y, yhat), I32_LO, I32_HI);
    for (int i = 0; i < MODEL_ORDER; i++)
      theta[i] = clampv(sadd(theta[i], mul_round(gain[i], e, 44)), I32_LO, I32_HI);
    for (int i = 0; i < MODEL_ORDER; i++)
      for (int j = 0; j < MODEL_ORDER; j++)
        cov[i][j] = clampv(div_trunc(ssub(cov[i][j], mul_round(gain[i], w[j], 44)),
                                     30, lam), COV_LO, COV_HI);
    // newest sample goes to the head of each half of the regressor
    for (int i = NRATE - 1; i >= 1; i--) phi[i] = phi[i - 1];
    phi[0] = y;
    for (int i = MODEL_ORDER - 1; i >= NRATE + 1; i--) phi[i] = phi[i - 1];
    if (NRATE < MODEL_ORDER) phi[NRATE] = u;
    r.c_r1 = tap(0);
    r.c_r2 = tap(1);
    r.c_u1 = tap(2);
    r.c_u2 = tap(3);
    r.err = e;
    r.clip = sat_seen;
    return r;
  endfunction

  initial begin
    err_count = 0;
    checked_count = 0;
    clip_count = 0;
    model_reset();
  end

  assign outstanding = pending_results.size();

  always @(posedge clk) begin
    rls_result_t want;
    if (rst) begin
      model_reset();
      pending_results.delete();
    end else begin
      if (wr_en) apply_write(wr_index, wr_data);
      if (in_valid && in_ready)
        pending_results.push_back(rls_update(measured_rate, command_rate));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          err_count++;
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (clipped) clip_count++;
          if (coef_rate1 !== want.c_r1) begin
            $error("coef_rate1: expected %0d, got %0d", want.c_r1, coef_rate1);
            err_count++;
          end
          if (coef_rate2 !== want.c_r2) begin
            $error("coef_rate2: expected %0d, got %0d", want.c_r2, coef_rate2);
            err_count++;
          end
          if (coef_cmd1 !== want.c_u1) begin
            $error("coef_cmd1: expected %0d, got %0d", want.c_u1, coef_cmd1);
            err_count++;
          end
          if (coef_cmd2 !== want.c_u2) begin
            $error("coef_cmd2: expected %0d, got %0d", want.c_u2, coef_cmd2);
            err_count++;
          end
          if (prediction_error !== want.err) begin
            $error("prediction_error: expected %0d, got %0d", want.err, prediction_error);
            err_count++;
          end
          if (clipped !== want.clip) begin
            $error("clipped: expected %0b, got %0b", want.clip, clipped);
            err_count++;
          end
        end
      end
    end
  end

endmodule

// ===== sim/tb_arx_recursive_least_squares.sv =====
// Stimulus and verdict for the ARX recursive least squares estimator.
`timescale 1ns / 1ps
module tb_arx_recursive_least_squares;
  import arxrls_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int     NUM_PHASES = 10;
  localparam int     RAND_PER_PHASE = 92;
  localparam logic [2:0] REG_COEF_R2 = 3'd2;
  localparam logic [2:0] REG_COEF_U1 = 3'd3;
  localparam logic [2:0] REG_COEF_U2 = 3'd4;
  localparam logic [2:0] REG_SPARE0 = 3'd6;
  localparam logic [2:0] REG_SPARE1 = 3'd7;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en = 1'b0;
  logic [2:0]         wr_index = '0;
  logic [46:0]        wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] measured_rate = '0;
  logic signed [31:0] command_rate = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] coef_rate1, coef_rate2, coef_cmd1, coef_cmd2;
  logic signed [31:0] prediction_error;
  logic               clipped;

  int     err_count, outstanding, checked_count, clip_count;
  int     sent_count = 0;
  int     ready_hold = 0;
  logic   no_stall = 1'b0;
  longint cycles = 0;

  always #2 clk = ~clk;

  arx_recursive_least_squares u_dut (.*);

  rls_result_monitor u_mon (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls: mostly short, a few long
  always @(negedge clk) begin
    if (no_stall) begin
      out_ready <= 1'b1;
    end else if (ready_hold == 0) begin
      out_ready <= ($urandom_range(0, 3) != 0);
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300)
                                                : $urandom_range(1, 6);
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // called just after a falling edge; leaves valid high after acceptance
  task automatic send_sample(logic signed [31:0] y, logic signed [31:0] u);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    measured_rate <= y;
    command_rate <= u;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [46:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] small_q(int span_log2);
    return $signed($urandom_range(0, (1 << (span_log2 + 1)))) - (1 << span_log2);
  endfunction

  function automatic logic signed [31:0] any_q();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return small_q($urandom_range(16, 26));
    if (pick < 88) return $urandom;
    case ($urandom_range(0, 4))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  task automatic set_config(int phase);
    logic [30:0] lam;
    logic [46:0] diag;
    case (phase)
      1: lam = LAM_MIN;
      2: lam = LAM_MAX;
      3: lam = 31'd0;               // below range, clamps up
      4: lam = 31'h7FFF_FFFF;       // above range, clamps down
      default: lam = 31'($urandom_range(LAM_MIN, LAM_MAX));
    endcase
    case (phase)
      2: diag = '0;
      5: diag = '1;
      default: diag = 47'({$urandom_range(0, 32'h7FFF), $urandom} >> $urandom_range(0, 14));
    endcase
    write_reg(REG_LAMBDA, {16'd0, lam});
    write_reg(REG_COEF_R1, {15'd0, (phase == 6) ? Q_MAX : small_q(25)});
    write_reg(REG_COEF_R2, {15'd0, (phase == 6) ? Q_MIN : small_q(25)});
    write_reg(REG_COEF_U1, {15'd0, (phase == 7) ? 32'h5555_5555 : small_q(22)});
    write_reg(REG_COEF_U2, {15'd0, (phase == 7) ? 32'hAAAA_AAAA : small_q(22)});
    write_reg(REG_COV, diag);
    if (phase == 8) begin
      write_reg(REG_SPARE0, '1);
      write_reg(REG_SPARE1, '0);
    end
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic signed [31:0] y1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes at reset settings
    send_sample(32'sd0, 32'sd0);
    send_sample(Q_MAX, Q_MAX);
    send_sample(Q_MIN, Q_MIN);
    send_sample(Q_MAX, Q_MIN);
    send_sample(Q_MIN, Q_MAX);
    send_sample(32'sd16777216, 32'sd1677721);
    send_sample(-32'sd16777216, -32'sd1677721);
    send_sample(32'h5555_5555, 32'hAAAA_AAAA);
    send_sample(32'hAAAA_AAAA, 32'h5555_5555);
    send_sample(32'sd1, -32'sd1);
    send_sample(32'sd0, 32'sd0);
    drain();

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      set_config(ph);
      no_stall <= (ph == 9);
      y1 = 0;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // sender holds off until the pipeline is empty
        if (ph == 3 && n == RAND_PER_PHASE / 2) drain();
        if ($urandom_range(0, 3) != 0) begin
          // plausible plant: rate follows its own past plus a small command
          y1 = (y1 >>> 1) + small_q(20);
          send_sample(y1, small_q(22));
        end else begin
          send_sample(any_q(), any_q());
        end
      end
      drain();
    end
    no_stall <= 1'b0;
    repeat (50) @(negedge clk);

    $display("sent %0d samples over %0d register settings; checked %0d results, %0d clipped",
             sent_count, NUM_PHASES + 1, checked_count, clip_count);
    if (err_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== arx_recursive_least_squares.f =====
rtl/arxrls_pkg.sv
rtl/arxrls_mul.sv
rtl/arxrls_div.sv
rtl/arxrls_dp.sv
rtl/arxrls_ctrl.sv
rtl/arx_recursive_least_squares.sv
sim/rls_result_monitor.sv
sim/tb_arx_recursive_least_squares.sv
